// ===== hdl/ihc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihc_pkg
// Types and constants shared by the ipv4 header checker modules.
// ----------------------------------------------------------------------------
package ihc_pkg;

  localparam int IDX_W  = 6;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;

  localparam logic [WORD_W-1:0] SUM_START     = 16'hffff;
  localparam logic [BYTE_W-1:0] VER_LEN_RESET = 8'h45;

  localparam logic [IDX_W-1:0] VER_OFS     = 6'd0;
  localparam logic [IDX_W-1:0] PROTO_OFS   = 6'd9;
  localparam logic [IDX_W-1:0] CSUM_HI_OFS = 6'd10;
  localparam logic [IDX_W-1:0] CSUM_LO_OFS = 6'd11;

  localparam logic [1:0] ST_ACCEPTED    = 2'd0;
  localparam logic [1:0] ST_BAD_VERSION = 2'd1;
  localparam logic [1:0] ST_BAD_CSUM    = 2'd2;

  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_UDP   = 2'd1;
  localparam logic [1:0] CLS_TCP   = 2'd2;
  localparam logic [1:0] CLS_ICMP  = 2'd3;

  localparam logic [BYTE_W-1:0] PROTO_UDP  = 8'd17;
  localparam logic [BYTE_W-1:0] PROTO_TCP  = 8'd6;
  localparam logic [BYTE_W-1:0] PROTO_ICMP = 8'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
  } ihc_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        protocol_class;
    logic [BYTE_W-1:0] protocol_number;
  } ihc_out_t;

  typedef struct packed {
    logic item_valid;
    logic step;
  } ihc_flow_t;

endpackage

// ===== hdl/ipv4_header_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_checker
// Checks the ipv4 header of a byte stream: version/length, header checksum
// and protocol class, one verdict per header.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   ihc_in_t  (data_byte, first_byte)
//   out_     output     out_valid / out_ready ihc_out_t (status, class, number)
//   cfg_     input      cfg_valid / cfg_ready expected version/length byte
//
// one byte request per cycle while in_ready is high; a verdict is shown on out_ once
// the last header byte has passed the input register, then the result register
// synchronous reset; after reset bytes are ignored until one marked first
// in_ready drops only while the input register is full and a verdict waits
// cfg_ready is always high
// ----------------------------------------------------------------------------
module ipv4_header_checker
  import ihc_pkg::*;
#(
  parameter int HEADER_BYTES = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ihc_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ihc_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data
);

  logic [BYTE_W-1:0] exp_ver_r;
  logic [BYTE_W-1:0] exp_ver_nxt;
  ihc_flow_t         flow;
  ihc_in_t           item;
  logic              out_free;
  logic              res_load;
  ihc_out_t          res_data;

  assign cfg_ready   = 1'b1;
  assign exp_ver_nxt = (cfg_valid && cfg_ready) ? cfg_data : exp_ver_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= VER_LEN_RESET;
    end else begin
      exp_ver_r <= exp_ver_nxt;
    end
  end

  ihc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .drain_ok (out_free),
    .flow     (flow),
    .item     (item)
  );

  ihc_hdr_core #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_hdr_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .flow        (flow),
    .item        (item),
    .exp_ver_len (exp_ver_r),
    .res_load    (res_load),
    .res_data    (res_data)
  );

  ihc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .load_data (res_data),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_class_only_when_accepted : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_ACCEPTED || out_data.protocol_class == CLS_OTHER))
    else $error("protocol class set on a rejected header");

  a_udp_number : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.protocol_class == CLS_UDP) |-> out_data.protocol_number == PROTO_UDP)
    else $error("udp class with wrong protocol number");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (flow.item_valid && out_valid && !out_ready))
    else $error("input stalled without a waiting verdict");

  a_load_needs_room : assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (flow.step && out_free))
    else $error("verdict loaded into a full result register");

endmodule

// ===== hdl/ihc_in_reg.sv =====
// ----------------------------------------------------------------------------
// ihc_in_reg
// Input register: holds one byte request until the header core takes it.
// ----------------------------------------------------------------------------
module ihc_in_reg
  import ihc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ihc_in_t   in_data,
  input  logic      drain_ok,
  output ihc_flow_t flow,
  output ihc_in_t   item
);

  logic    valid_r;
  logic    valid_nxt;
  ihc_in_t data_r;
  logic    take;
  logic    accept;

  assign take     = valid_r & drain_ok;
  assign in_ready = ~valid_r | drain_ok;
  assign accept   = in_valid & in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data;
    end
  end

  assign flow.item_valid = valid_r;
  assign flow.step       = take;
  assign item            = data_r;

endmodule

// ===== hdl/ihc_hdr_core.sv =====
// ----------------------------------------------------------------------------
// ihc_hdr_core
// Header tracking, end-around checksum accumulation and verdict per header.
// ----------------------------------------------------------------------------
module ihc_hdr_core
  import ihc_pkg::*;
#(
  parameter int HEADER_BYTES = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ihc_flow_t         flow,
  input  ihc_in_t           item,
  input  logic [BYTE_W-1:0] exp_ver_len,
  output logic              res_load,
  output ihc_out_t          res_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HEADER_BYTES - 1);

  logic [IDX_W-1:0]  idx_r,      idx_nxt;
  logic [WORD_W-1:0] sum_r,      sum_nxt;
  logic [BYTE_W-1:0] pend_r,     pend_nxt;
  logic [WORD_W-1:0] csum_r,     csum_nxt;
  logic              ver_ok_r,   ver_ok_nxt;
  logic [BYTE_W-1:0] proto_r,    proto_nxt;
  logic              finished_r, finished_nxt;

  logic [IDX_W-1:0]  idx_cur;
  logic [WORD_W-1:0] sum_base;
  logic [WORD_W-1:0] csum_base;
  logic              active;
  logic              is_last;
  logic              add_en;
  logic [WORD_W-1:0] add_word;
  logic [WORD_W:0]   sum_wide;
  logic [WORD_W-1:0] sum_added;
  logic [1:0]        status;
  logic [1:0]        cls;

  assign active    = flow.step & (item.first_byte | ~finished_r);
  assign idx_cur   = item.first_byte ? '0 : idx_r;
  assign sum_base  = item.first_byte ? SUM_START : sum_r;
  assign csum_base = item.first_byte ? '0 : csum_r;
  assign is_last   = (idx_cur == LAST_IDX);

  always_comb begin
    add_en   = 1'b0;
    add_word = '0;
    if (idx_cur[0]) begin
      if (idx_cur != CSUM_LO_OFS) begin
        add_en   = 1'b1;
        add_word = {pend_r, item.data_byte};
      end
    end else if (idx_cur != CSUM_HI_OFS && is_last) begin
      // odd length: trailing byte pairs with a zero low byte
      add_en   = 1'b1;
      add_word = {item.data_byte, {BYTE_W{1'b0}}};
    end
  end

  // end-around reduction: subtracting 0xffff equals dropping the carry and adding one
  assign sum_wide  = {1'b0, sum_base} + {1'b0, add_word};
  assign sum_added = sum_wide[WORD_W] ? (sum_wide[WORD_W-1:0] + WORD_W'(1))
                                      : sum_wide[WORD_W-1:0];

  always_comb begin
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    pend_nxt     = pend_r;
    csum_nxt     = csum_r;
    ver_ok_nxt   = ver_ok_r;
    proto_nxt    = proto_r;
    finished_nxt = finished_r;
    if (active) begin
      idx_nxt      = idx_cur + IDX_W'(1);
      sum_nxt      = add_en ? sum_added : sum_base;
      csum_nxt     = csum_base;
      finished_nxt = is_last;
      if (item.first_byte) begin
        ver_ok_nxt = 1'b0;
        proto_nxt  = '0;
      end
      if (idx_cur == VER_OFS) begin
        ver_ok_nxt = (item.data_byte == exp_ver_len);
      end
      if (idx_cur == PROTO_OFS) begin
        proto_nxt = item.data_byte;
      end
      if (!idx_cur[0]) begin
        pend_nxt = item.data_byte;
      end
      if (idx_cur == CSUM_HI_OFS) begin
        csum_nxt = {item.data_byte, {BYTE_W{1'b0}}};
      end else if (idx_cur == CSUM_LO_OFS) begin
        csum_nxt = {csum_base[WORD_W-1:BYTE_W], item.data_byte};
      end
    end
  end

  always_comb begin
    status = ST_ACCEPTED;
    cls    = CLS_OTHER;
    priority if (!ver_ok_nxt) begin
      status = ST_BAD_VERSION;
    end else if (csum_nxt != ~sum_nxt) begin
      status = ST_BAD_CSUM;
    end else if (proto_nxt == PROTO_UDP) begin
      cls = CLS_UDP;
    end else if (proto_nxt == PROTO_TCP) begin
      cls = CLS_TCP;
    end else if (proto_nxt == PROTO_ICMP) begin
      cls = CLS_ICMP;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign res_load                 = active & is_last;
  assign res_data.status          = status;
  assign res_data.protocol_class  = cls;
  assign res_data.protocol_number = proto_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      sum_r      <= SUM_START;
      pend_r     <= '0;
      csum_r     <= '0;
      ver_ok_r   <= 1'b0;
      proto_r    <= '0;
      finished_r <= 1'b1;
    end else begin
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
      pend_r     <= pend_nxt;
      csum_r     <= csum_nxt;
      ver_ok_r   <= ver_ok_nxt;
      proto_r    <= proto_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

// ===== hdl/ihc_out_reg.sv =====
// ----------------------------------------------------------------------------
// ihc_out_reg
// Result register: holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module ihc_out_reg
  import ihc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  ihc_out_t load_data,
  output logic     free,
  output logic     out_valid,
  input  logic     out_ready,
  output ihc_out_t out_data
);

  logic     valid_r;
  logic     valid_nxt;
  ihc_out_t data_r;

  assign free = ~valid_r | out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
